// File: rtl/drf_pkg.sv
// drf_pkg: widths, codes and the controller/datapath interface types shared by
// every module of the double reflection frame block. Depends on nothing.

package drf_pkg;

    localparam int FRAC_BITS   = 16;            // fraction bits of t, r and s
    localparam int PT_W        = 32;            // point coordinate, Q16.16
    localparam int VEC_W       = 18;            // t, r and s components, Q2.16
    localparam int THR_W       = 17;            // tangent length threshold
    localparam logic [THR_W-1:0] THR_RESET = 17'd66;

    localparam int X_W         = 22;            // working r and reflected old tangent
    localparam int V_W         = 34;            // mirror vector before shrinking
    localparam int VMAX_EXP    = 16;            // shrunk components stay below 2^16
    localparam int D_W         = 34;            // v.v of a shrunk vector
    localparam int ACC_W       = 40;            // dot products and cross terms
    localparam int MA_W        = 40;            // multiplier operand A
    localparam int MB_W        = 18;            // multiplier operand B
    localparam int P_W         = MA_W + MB_W;   // product
    localparam int QW          = 21;            // quotient bits of one reflection term
    localparam int NUM_W       = QW + D_W;      // divider dividend
    localparam int QCNT_W      = $clog2(QW + 1);

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // capture the input item
        OP_R_INIT,      // r = initial reference vector
        OP_CHORD,       // v = chord, working r and tangent from the stored frame
        OP_DIFF,        // v = new tangent - reflected old tangent
        OP_VOR,         // or of the component magnitudes of v
        OP_VSHIFT,      // halve v (floor)
        OP_D_STORE,     // d = v.v
        OP_N_STORE,     // n = v.x
        OP_DIV_START,   // launch rounded (2 n v_c) / d
        OP_APPLY_X,     // r_c -= quotient
        OP_APPLY_Y,     // old tangent_c -= quotient
        OP_R_STORE,     // r = sat(working r)
        OP_S_STORE,     // s_c = sat(round(cross term))
        OP_OUT_LOAD     // store point and tangent, fill the output register
    } dp_op_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_TT,         // t_c * t_c
        MUL_THR,        // threshold squared
        MUL_VV,         // v_c * v_c
        MUL_VX,         // r_c * v_c
        MUL_VY,         // old tangent_c * v_c
        MUL_NV,         // n * v_c
        MUL_CR1,        // t_(c+1) * r_(c+2)
        MUL_CR2         // t_(c+2) * r_(c+1)
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        dp_op_t     op;
        mul_sel_t   mul;
        acc_op_t    acc;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic tn_short;     // accumulator below product (tangent too short)
        logic acc_zero;
        logic need_shift;   // mirror vector still too large
        logic div_busy;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RINIT,
        ST_TN,
        ST_TCMP,
        ST_CHORD,
        ST_DIFF,
        ST_VOR,
        ST_SHR,
        ST_DOTD,
        ST_DSTORE,
        ST_DOTN,
        ST_NSTORE,
        ST_NUM,
        ST_DLOAD,
        ST_DIV,
        ST_RSTORE,
        ST_CROSS,
        ST_OUT
    } ctrl_state_t;

    function automatic logic [1:0] comp_next(input logic [1:0] c);
        logic [1:0] r;
        unique case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] comp_prev(input logic [1:0] c);
        logic [1:0] r;
        unique case (c)
            2'd0:    r = 2'd2;
            2'd2:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/drf_div.sv
// drf_div: restoring divider, one quotient bit a cycle, for the reflection terms.
// Depends on drf_pkg.

module drf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [drf_pkg::NUM_W-1:0]   num,
    input  logic [drf_pkg::D_W-1:0]     den,
    output logic                        busy,
    output logic [drf_pkg::QW-1:0]      quo
);
    import drf_pkg::*;

    logic [D_W-1:0]    rem_reg, rem_next;
    logic [QW-1:0]     sh_reg, sh_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[QW-1]};
        diff      = trial - {1'b0, den};
        ge        = (trial >= {1'b0, den});
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num[NUM_W-1:QW];
            sh_next   = num[QW-1:0];
            cnt_next  = QCNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            sh_next   = {sh_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != QCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign busy = busy_reg;
    assign quo  = sh_reg;

endmodule

// File: rtl/drf_dp.sv
// drf_dp: frame datapath - stored frame, working vectors, shared multiplier and
// accumulator, shrink shifter and the divider. Depends on drf_pkg and drf_div.

module drf_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drf_pkg::dp_cmd_t                cmd,
    output drf_pkg::dp_stat_t               stat,
    input  logic                            cfg_wr,
    input  logic [drf_pkg::THR_W-1:0]       cfg_thr,
    input  logic [drf_pkg::IN_TDATA_W-1:0]  in_data,
    output logic [drf_pkg::OUT_TDATA_W-1:0] out_data
);
    import drf_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 <<< (VEC_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1 <<< (FRAC_BITS - 1));

    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a;
        if (a > SAT_HI)
            s = SAT_HI;
        else if (a < SAT_LO)
            s = SAT_LO;
        return s[VEC_W-1:0];
    endfunction

    logic [THR_W-1:0]              thr_reg, thr_next;
    logic signed [PT_W-1:0]        p_reg [3], p_next [3];
    logic signed [PT_W-1:0]        pp_reg [3], pp_next [3];
    logic signed [VEC_W-1:0]       t_reg [3], t_next [3];
    logic signed [VEC_W-1:0]       ir_reg [3], ir_next [3];
    logic signed [VEC_W-1:0]       pt_reg [3], pt_next [3];
    logic signed [VEC_W-1:0]       pr_reg [3], pr_next [3];
    logic signed [VEC_W-1:0]       ps_reg [3], ps_next [3];
    logic signed [X_W-1:0]         x_reg [3], x_next [3];
    logic signed [X_W-1:0]         y_reg [3], y_next [3];
    logic signed [V_W-1:0]         v_reg [3], v_next [3];
    logic [V_W-1:0]                or_reg, or_next;
    logic signed [P_W-1:0]         prod_reg, prod_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [D_W-1:0]                d_reg, d_next;
    logic signed [ACC_W-1:0]       n_reg, n_next;
    logic [OUT_TDATA_W-1:0]        out_reg, out_next;

    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic signed [P_W-1:0]         mul_p;
    logic signed [ACC_W-1:0]       prod_acc;
    logic [1:0]                    idx_n, idx_p;
    logic [P_W-1:0]                prod_abs;
    logic [NUM_W-1:0]              div_num;
    logic                          div_start, div_busy;
    logic [QW-1:0]                 quo;
    logic signed [X_W-1:0]         q_signed;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [ACC_W-1:0]       rnd_sh;
    logic [V_W-1:0]                mag [3];

    assign idx_n    = comp_next(cmd.idx);
    assign idx_p    = comp_prev(cmd.idx);
    assign prod_acc = prod_reg[ACC_W-1:0];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul)
            MUL_TT:
            begin
                mul_a = MA_W'(t_reg[cmd.idx]);
                mul_b = t_reg[cmd.idx];
            end
            MUL_THR:
            begin
                mul_a = MA_W'({1'b0, thr_reg});
                mul_b = $signed({1'b0, thr_reg});
            end
            MUL_VV:
            begin
                mul_a = MA_W'($signed(v_reg[cmd.idx][MB_W-1:0]));
                mul_b = v_reg[cmd.idx][MB_W-1:0];
            end
            MUL_VX:
            begin
                mul_a = MA_W'(x_reg[cmd.idx]);
                mul_b = v_reg[cmd.idx][MB_W-1:0];
            end
            MUL_VY:
            begin
                mul_a = MA_W'(y_reg[cmd.idx]);
                mul_b = v_reg[cmd.idx][MB_W-1:0];
            end
            MUL_NV:
            begin
                mul_a = n_reg;
                mul_b = v_reg[cmd.idx][MB_W-1:0];
            end
            MUL_CR1:
            begin
                mul_a = MA_W'(t_reg[idx_n]);
                mul_b = pr_reg[idx_p];
            end
            MUL_CR2:
            begin
                mul_a = MA_W'(t_reg[idx_p]);
                mul_b = pr_reg[idx_n];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // rounded magnitude of 2 n v_c plus half the divisor
    assign prod_abs  = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
    assign div_num   = {prod_abs[NUM_W-2:0], 1'b0} + NUM_W'(d_reg[D_W-1:1]);
    assign div_start = (cmd.op == OP_DIV_START);
    assign q_signed  = prod_reg[P_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    assign rnd    = acc_reg + HALF;
    assign rnd_sh = rnd >>> FRAC_BITS;

    drf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            mag[c] = v_reg[c][V_W-1] ? V_W'(-v_reg[c]) : V_W'(v_reg[c]);
    end

    always_comb
    begin
        thr_next  = cfg_wr ? cfg_thr : thr_reg;
        p_next    = p_reg;
        pp_next   = pp_reg;
        t_next    = t_reg;
        ir_next   = ir_reg;
        pt_next   = pt_reg;
        pr_next   = pr_reg;
        ps_next   = ps_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        v_next    = v_reg;
        or_next   = or_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        out_next  = out_reg;
        prod_next = (cmd.mul == MUL_NONE) ? prod_reg : mul_p;

        unique case (cmd.acc)
            ACC_LOAD: acc_next = prod_acc;
            ACC_ADD:  acc_next = acc_reg + prod_acc;
            ACC_SUB:  acc_next = acc_reg - prod_acc;
            default:  acc_next = acc_reg;
        endcase

        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p_next[c]  = in_data[PT_W*c +: PT_W];
                    t_next[c]  = in_data[3*PT_W + VEC_W*c +: VEC_W];
                    ir_next[c] = in_data[3*PT_W + 3*VEC_W + VEC_W*c +: VEC_W];
                end
            end
            OP_R_INIT:
                pr_next = ir_reg;
            OP_CHORD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v_next[c] = V_W'(p_reg[c]) - V_W'(pp_reg[c]);
                    x_next[c] = X_W'(pr_reg[c]);
                    y_next[c] = X_W'(pt_reg[c]);
                end
            end
            OP_DIFF:
            begin
                for (int c = 0; c < 3; c++)
                    v_next[c] = V_W'(t_reg[c]) - V_W'(y_reg[c]);
            end
            OP_VOR:
                or_next = mag[0] | mag[1] | mag[2];
            OP_VSHIFT:
            begin
                for (int c = 0; c < 3; c++)
                    v_next[c] = v_reg[c] >>> 1;
                or_next = or_reg >> 1;
            end
            OP_D_STORE:
                d_next = acc_reg[D_W-1:0];
            OP_N_STORE:
                n_next = acc_reg;
            OP_APPLY_X:
            begin
                for (int c = 0; c < 3; c++)
                    if (cmd.idx == 2'(c))
                        x_next[c] = x_reg[c] - q_signed;
            end
            OP_APPLY_Y:
            begin
                for (int c = 0; c < 3; c++)
                    if (cmd.idx == 2'(c))
                        y_next[c] = y_reg[c] - q_signed;
            end
            OP_R_STORE:
            begin
                for (int c = 0; c < 3; c++)
                    pr_next[c] = sat_vec(ACC_W'(x_reg[c]));
            end
            OP_S_STORE:
            begin
                for (int c = 0; c < 3; c++)
                    if (cmd.idx == 2'(c))
                        ps_next[c] = sat_vec(rnd_sh);
            end
            OP_OUT_LOAD:
            begin
                pp_next  = p_reg;
                pt_next  = t_reg;
                out_next = {{(OUT_TDATA_W - 6*VEC_W){1'b0}},
                            ps_reg[2], ps_reg[1], ps_reg[0],
                            pr_reg[2], pr_reg[1], pr_reg[0]};
            end
            default:
            begin
                // OP_NONE and OP_DIV_START leave the vector registers alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            for (int c = 0; c < 3; c++)
            begin
                pp_reg[c] <= '0;
                pt_reg[c] <= '0;
                pr_reg[c] <= '0;
                ps_reg[c] <= '0;
            end
        end
        else
        begin
            thr_reg <= thr_next;
            pp_reg  <= pp_next;
            pt_reg  <= pt_next;
            pr_reg  <= pr_next;
            ps_reg  <= ps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        t_reg    <= t_next;
        ir_reg   <= ir_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        v_reg    <= v_next;
        or_reg   <= or_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        out_reg  <= out_next;
    end

    assign stat.tn_short   = (acc_reg < prod_acc);
    assign stat.acc_zero   = (acc_reg == '0);
    assign stat.need_shift = |or_reg[V_W-1:VMAX_EXP];
    assign stat.div_busy   = div_busy;
    assign out_data        = out_reg;

endmodule

// File: rtl/drf_ctrl.sv
// drf_ctrl: sequencer for the frame datapath - handshakes, reflection passes and
// the cross product. Depends on drf_pkg.

module drf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output drf_pkg::dp_cmd_t  cmd,
    input  drf_pkg::dp_stat_t stat
);
    import drf_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;
    logic        pass_reg, pass_next;
    logic        tgt_reg, tgt_next;
    logic        started_reg, started_next;
    logic        out_valid_reg, out_valid_next;

    // three products into the accumulator: first loads, the rest add
    function automatic acc_op_t mac_acc(input logic [1:0] c);
        acc_op_t a;
        unique case (c)
            2'd0:    a = ACC_HOLD;
            2'd1:    a = ACC_LOAD;
            default: a = ACC_ADD;
        endcase
        return a;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        tgt_next       = tgt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.mul        = MUL_NONE;
        cmd.acc        = ACC_HOLD;
        cmd.idx        = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op   = OP_LOAD;
                    cnt_next = 2'd0;
                    idx_next = 2'd0;
                    if (!in_action)
                    begin
                        started_next = 1'b1;
                        state_next   = ST_RINIT;
                    end
                    else if (started_reg)
                        state_next = ST_TN;
                end
            end
            ST_RINIT:
            begin
                cmd.op     = OP_R_INIT;
                state_next = ST_CROSS;
            end
            ST_TN:
            begin
                cmd.idx  = cnt_reg;
                cmd.mul  = (cnt_reg == 2'd3) ? MUL_THR : MUL_TT;
                cmd.acc  = mac_acc(cnt_reg);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = ST_TCMP;
            end
            ST_TCMP:
                state_next = stat.tn_short ? ST_OUT : ST_CHORD;
            ST_CHORD:
            begin
                cmd.op     = OP_CHORD;
                pass_next  = 1'b0;
                state_next = ST_VOR;
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                pass_next  = 1'b1;
                state_next = ST_VOR;
            end
            ST_VOR:
            begin
                cmd.op     = OP_VOR;
                state_next = ST_SHR;
            end
            ST_SHR:
            begin
                if (stat.need_shift)
                    cmd.op = OP_VSHIFT;
                else
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_DOTD;
                end
            end
            ST_DOTD:
            begin
                cmd.idx  = cnt_reg;
                cmd.mul  = (cnt_reg == 2'd3) ? MUL_NONE : MUL_VV;
                cmd.acc  = mac_acc(cnt_reg);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = ST_DSTORE;
            end
            ST_DSTORE:
            begin
                cmd.op = OP_D_STORE;
                if (stat.acc_zero)
                    state_next = pass_reg ? ST_RSTORE : ST_DIFF;
                else
                begin
                    tgt_next   = 1'b0;
                    cnt_next   = 2'd0;
                    state_next = ST_DOTN;
                end
            end
            ST_DOTN:
            begin
                cmd.idx = cnt_reg;
                if (cnt_reg == 2'd3)
                    cmd.mul = MUL_NONE;
                else
                    cmd.mul = tgt_reg ? MUL_VY : MUL_VX;
                cmd.acc  = mac_acc(cnt_reg);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = ST_NSTORE;
            end
            ST_NSTORE:
            begin
                cmd.op     = OP_N_STORE;
                idx_next   = 2'd0;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.mul    = MUL_NV;
                state_next = ST_DLOAD;
            end
            ST_DLOAD:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = tgt_reg ? OP_APPLY_Y : OP_APPLY_X;
                    if (idx_reg != 2'd2)
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_NUM;
                    end
                    else if (!pass_reg && !tgt_reg)
                    begin
                        tgt_next   = 1'b1;
                        cnt_next   = 2'd0;
                        state_next = ST_DOTN;
                    end
                    else if (!pass_reg)
                        state_next = ST_DIFF;
                    else
                        state_next = ST_RSTORE;
                end
            end
            ST_RSTORE:
            begin
                cmd.op     = OP_R_STORE;
                idx_next   = 2'd0;
                cnt_next   = 2'd0;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                unique case (cnt_reg)
                    2'd0: cmd.mul = MUL_CR1;
                    2'd1:
                    begin
                        cmd.mul = MUL_CR2;
                        cmd.acc = ACC_LOAD;
                    end
                    2'd2: cmd.acc = ACC_SUB;
                    default: cmd.op = OP_S_STORE;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    if (idx_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                        idx_next = idx_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            tgt_reg       <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            tgt_reg       <= tgt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/double_reflection_frame.sv
// double_reflection_frame: top level, rotation-minimising frame by double reflection.
// A start request sets r and forms the cross product; an advance with a short tangent
// keeps the frame, otherwise the chord and tangent difference are halved until small, and
// coincident points or a zero tangent difference skip the matching reflection.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: rst_n asynchronous, clears the frame, threshold to 66, no frame started.

module double_reflection_frame (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x, point_y, point_z, tangent_x, tangent_y, tangent_z,
    // init_r_x, init_r_y, init_r_z (lowest bit up, zero pad to 208)
    input  logic [drf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // action: 0 start frame, 1 advance
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // frame_r_x, frame_r_y, frame_r_z, frame_s_x, frame_s_y, frame_s_z
    // (lowest bit up, zero pad to 112)
    output logic [drf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // threshold register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drf_pkg::THR_W-1:0]           cfg_data
);
    import drf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The register takes a write in any cycle; writes are expected only while idle.
    assign cfg_ready = 1'b1;

    // Sequencer: accepts a request in idle; a start sets r and forms the cross product, an
    // advance checks the tangent, then unless it is short runs both reflections and the cross
    // product; the result waits in the output register while the next request can be taken.
    drf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: stored frame, working vectors, one shared multiplier with
    // accumulator, shrink shifter and an iterative divider.
    drf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_wr   (cfg_valid),
        .cfg_thr  (cfg_data),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule
